>>> rtl/core/lfga_pkg.sv
// ----------------------------------------------------------------------------
// Lowest free gate allocator package
// Shared constants and types for the allocator core and its sub-blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package lfga_pkg;

    // Parameter defaults for the top level.
    localparam int NUM_GATES_DEF = 16;
    localparam int TIME_BITS_DEF = 32;

    // Fixed field widths on the stream and configuration ports.
    localparam int FIELD_TIME_W = 32;
    localparam int GATE_NUM_W   = 5;
    localparam int COUNT_W      = 16;
    localparam int CFG_W        = 5;
    localparam int IN_DATA_W    = 64;
    localparam int OUT_DATA_W   = 24;

    // Reset value of the gates-in-use register and the count ceiling.
    localparam logic [CFG_W-1:0]   GATES_RESET = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

    // Result of the lowest-free search.
    typedef struct packed {
        logic                  found;
        logic [GATE_NUM_W-1:0] number;
    } t_pick;

endpackage

`default_nettype wire

>>> rtl/core/lfga_gate_bank.sv
// ----------------------------------------------------------------------------
// Gate bank
// Holds busy flags and leave times, releases expired gates for the current
// request and records the granted gate.
// ----------------------------------------------------------------------------
`default_nettype none

module lfga_gate_bank #(
    parameter int NUM_GATES = lfga_pkg::NUM_GATES_DEF,
    parameter int TIME_BITS = lfga_pkg::TIME_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_step,
    input  wire logic [TIME_BITS-1:0]         i_arrive,
    input  wire logic [TIME_BITS-1:0]         i_leave,
    input  wire logic [lfga_pkg::CFG_W-1:0]   i_gates_in_use,
    input  wire logic [NUM_GATES-1:0]         i_grant,
    output logic      [NUM_GATES-1:0]         o_avail
);

    logic [NUM_GATES-1:0] r_busy;
    logic [NUM_GATES-1:0] n_busy;
    logic [TIME_BITS-1:0] r_leave [NUM_GATES];
    logic [NUM_GATES-1:0] w_busy_now;
    logic [NUM_GATES-1:0] w_elig;

    // Release every busy gate whose leave time is below the arrival time,
    // and mark which gates fall inside the configured limit.
    always_comb begin
        for (int g = 0; g < NUM_GATES; g++) begin
            w_busy_now[g] = r_busy[g] && !(r_leave[g] < i_arrive);
            w_elig[g]     = (g < int'(i_gates_in_use));
        end
        o_avail = ~w_busy_now & w_elig;
        n_busy  = w_busy_now | i_grant;
    end

    // Busy flags update on every processed request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else if (i_step) begin
            r_busy <= n_busy;
        end
    end

    // Leave time of the granted gate.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            for (int g = 0; g < NUM_GATES; g++) begin
                if (i_grant[g]) begin
                    r_leave[g] <= i_leave;
                end
            end
        end
    end

    // A granted gate is busy after the update.
    a_grant_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> ((r_busy & $past(i_grant)) == $past(i_grant)))
        else $error("granted gate not marked busy");

    // A gate only turns busy through a grant.
    a_busy_rise_from_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_busy & ~$past(r_busy) & ~$past(i_grant)) == '0))
        else $error("gate turned busy without a grant");

    // Without a request the busy flags hold.
    a_busy_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> (r_busy == $past(r_busy)))
        else $error("busy flags changed while idle");

endmodule

`default_nettype wire

>>> rtl/core/lfga_pick.sv
// ----------------------------------------------------------------------------
// Lowest free gate picker
// Finds the lowest available gate and returns it one-hot and as a number.
// ----------------------------------------------------------------------------
`default_nettype none

module lfga_pick #(
    parameter int NUM_GATES = lfga_pkg::NUM_GATES_DEF
) (
    input  wire logic [NUM_GATES-1:0] i_avail,
    output logic      [NUM_GATES-1:0] o_grant,
    output lfga_pkg::t_pick           o_pick
);

    localparam int NUM_W = lfga_pkg::GATE_NUM_W;

    logic [NUM_W-1:0] w_num;

    // Isolate the lowest set bit, then encode it as a gate number from 1.
    always_comb begin
        o_grant = i_avail & (~i_avail + NUM_GATES'(1));
        w_num   = '0;
        for (int g = 0; g < NUM_GATES; g++) begin
            if (o_grant[g]) begin
                w_num = w_num | NUM_W'(g + 1);
            end
        end
        o_pick.found  = |i_avail;
        o_pick.number = w_num;
    end

endmodule

`default_nettype wire

>>> rtl/core/lowest_free_gate_allocator_top.sv
// A word in the input register passes the gate search into the result register when that
// register is free. Throughput: one request word per cycle while results are taken; the gate
// search is a single compare and priority-encode pass between the two registers.
// Reset (synchronous, active low) frees every gate, clears the accepted count and
// sets gates_in_use to 16; leave times are not cleared.
// ----------------------------------------------------------------------------
// Lowest free gate allocator, top level
// Assigns each request the lowest free gate and keeps a saturating count of
// placed requests.
// ----------------------------------------------------------------------------
`default_nettype none

module lowest_free_gate_allocator_top #(
    parameter int NUM_GATES = lfga_pkg::NUM_GATES_DEF,
    parameter int TIME_BITS = lfga_pkg::TIME_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration: gates_in_use
    input  wire logic                              i_cfg_we,
    input  wire logic [lfga_pkg::CFG_W-1:0]        i_cfg_wdata,
    // Request stream
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // Fields from bit 0: arrive_time[31:0], leave_time[63:32]
    input  wire logic [lfga_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // Result stream
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // Fields from bit 0: placed[0], gate_number[5:1], accepted_total[21:6], zero pad
    output logic      [lfga_pkg::OUT_DATA_W-1:0]   o_m_tdata
);

    localparam int FW = lfga_pkg::FIELD_TIME_W;
    localparam int NW = lfga_pkg::GATE_NUM_W;
    localparam int CW = lfga_pkg::COUNT_W;

    logic [lfga_pkg::CFG_W-1:0] r_gates;
    logic                       r_in_valid;
    logic [TIME_BITS-1:0]       r_arrive;
    logic [TIME_BITS-1:0]       r_leave;
    logic                       r_out_valid;
    logic                       r_out_placed;
    logic [NW-1:0]              r_out_gate;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;

    logic                       w_adv;
    logic                       w_step;
    logic                       w_s_accept;
    logic [FW+TIME_BITS-1:0]    w_arrive_ext;
    logic [FW+TIME_BITS-1:0]    w_leave_ext;
    logic [NUM_GATES-1:0]       w_avail;
    logic [NUM_GATES-1:0]       w_grant;
    lfga_pkg::t_pick            w_pick;

    // Handshake: the result register frees when empty or taken.
    assign w_adv      = !r_out_valid || i_m_tready;
    assign w_step     = r_in_valid && w_adv;
    assign o_s_tready = !r_in_valid || w_adv;
    assign w_s_accept = i_s_tvalid && o_s_tready;

    // Times are taken in their low TIME_BITS bits.
    assign w_arrive_ext = {{TIME_BITS{1'b0}}, i_s_tdata[FW-1:0]};
    assign w_leave_ext  = {{TIME_BITS{1'b0}}, i_s_tdata[2*FW-1:FW]};

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gates <= lfga_pkg::GATES_RESET;
        end else if (i_cfg_we) begin
            r_gates <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_arrive <= w_arrive_ext[TIME_BITS-1:0];
            r_leave  <= w_leave_ext[TIME_BITS-1:0];
        end
    end

    // Gate state and release logic.
    lfga_gate_bank #(
        .NUM_GATES (NUM_GATES),
        .TIME_BITS (TIME_BITS)
    ) u_bank (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_arrive       (r_arrive),
        .i_leave        (r_leave),
        .i_gates_in_use (r_gates),
        .i_grant        (w_grant),
        .o_avail        (w_avail)
    );

    // Lowest free gate search.
    lfga_pick #(
        .NUM_GATES (NUM_GATES)
    ) u_pick (
        .i_avail (w_avail),
        .o_grant (w_grant),
        .o_pick  (w_pick)
    );

    // Saturating count of placed requests.
    assign n_count = (w_pick.found && (r_count != lfga_pkg::COUNT_MAX)) ?
                     r_count + CW'(1) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_step) begin
            r_count <= n_count;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_placed <= w_pick.found;
            r_out_gate   <= w_pick.number;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(lfga_pkg::OUT_DATA_W - CW - NW - 1){1'b0}},
                         r_count, r_out_gate, r_out_placed};

    // At most one gate is granted per request.
    a_grant_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_grant))
        else $error("more than one gate granted");

    // The accepted count never goes down outside reset.
    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count >= $past(r_count)))
        else $error("accepted count decreased");

    // A placed result carries a gate number, a rejected one reports gate 0.
    a_placed_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((NUM_GATES > 31) || (r_out_placed == (r_out_gate != '0))))
        else $error("placed flag and gate number disagree");

endmodule

`default_nettype wire
